// ===== hw/rtl/hswa_pkg.sv =====
// hswa_pkg: shared types, op codes, register addresses and rounding and saturation helpers
// for the householder sliding window apply block. No dependencies.
package hswa_pkg;

  localparam logic [1:0] OP_VEC = 2'd0;
  localparam logic [1:0] OP_TAU = 2'd1;
  localparam logic [1:0] OP_ROW = 2'd2;

  // APB byte addresses of the two registers
  localparam logic [2:0] ADDR_NUM_REFL = 3'd0;
  localparam logic [2:0] ADDR_REFL_LEN = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         reflector_index;
    logic [4:0]         element_index;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         out_row;
    logic signed [31:0] out_value;
    logic               column_done;
  } out_item_t;

  typedef struct packed {
    logic [6:0] num_reflectors;
    logic [5:0] reflector_len;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_VEC,
    CMD_TAU,
    CMD_ROW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [5:0]         ri;
    logic [4:0]         ei;
    logic signed [31:0] val;
  } cmd_t;

  // Q2.29 product back to Q2.29: round to nearest (ties up), saturate.
  function automatic logic signed [31:0] round_sat64(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = (x + 64'sd268435456) >>> 29;
    if (t > 64'sd2147483647) return 32'h7fffffff;
    else if (t < -64'sd2147483648) return 32'h80000000;
    else return t[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? 32'h80000000 : 32'h7fffffff;
    else return d[31:0];
  endfunction

endpackage

// ===== hw/rtl/hswa_front.sv =====
// hswa_front: accepts input transactions, classifies them into commands
// and drops ops that have no effect. Depends on hswa_pkg.
module hswa_front #(
  parameter int WINDOW         = 32,
  parameter int MAX_REFLECTORS = 64
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  hswa_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output hswa_pkg::cmd_t    push_cmd
);
  import hswa_pkg::*;

  logic ri_ok, ei_ok, keep;

  assign ri_ok = 32'(in_data.reflector_index) < 32'(MAX_REFLECTORS);
  assign ei_ok = 32'(in_data.element_index) < 32'(WINDOW);

  always_comb begin
    keep = 1'b0;
    push_cmd.kind = CMD_ROW;
    case (in_data.op)
      OP_VEC: begin
        keep = ri_ok && ei_ok;
        push_cmd.kind = CMD_VEC;
      end
      OP_TAU: begin
        keep = ri_ok;
        push_cmd.kind = CMD_TAU;
      end
      OP_ROW: begin
        keep = 1'b1;
        push_cmd.kind = CMD_ROW;
      end
      default: keep = 1'b0;
    endcase
    push_cmd.ri  = in_data.reflector_index;
    push_cmd.ei  = in_data.element_index;
    push_cmd.val = in_data.data_value;
  end

  // dropped ops are swallowed as soon as the queue could take one
  assign in_ready   = push_ready;
  assign push_valid = in_valid && keep;

endmodule

// ===== hw/rtl/hswa_fifo.sv =====
// hswa_fifo: two-entry command queue between front and back.
// Depends on hswa_pkg.
module hswa_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  hswa_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hswa_pkg::cmd_t pop_cmd
);
  import hswa_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_cmd    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/hswa_back.sv =====
// hswa_back: executes commands: table loads, window fill, reflector
// application on one shared multiplier, result emission. Depends on hswa_pkg.
module hswa_back #(
  parameter int WINDOW         = 32,
  parameter int MAX_REFLECTORS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hswa_pkg::cfg_t      cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  hswa_pkg::cmd_t      pop_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output hswa_pkg::out_item_t out_data
);
  import hswa_pkg::*;

  localparam int CW   = $clog2(MAX_REFLECTORS + WINDOW);
  localparam int NW   = $clog2(WINDOW + 1);
  localparam int KW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RIW  = (MAX_REFLECTORS > 1) ? $clog2(MAX_REFLECTORS) : 1;
  localparam int AW   = (MAX_REFLECTORS * WINDOW > 1) ? $clog2(MAX_REFLECTORS * WINDOW) : 1;
  localparam int ACCW = 65 + KW;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_DOT, S_DOTR, S_TMUL, S_TRND, S_UPD, S_EMIT
  } state_t;

  state_t             state_r;
  logic signed [31:0] win_r [WINDOW];
  logic [CW-1:0]      rows_seen_r;
  logic [RIW-1:0]     r_r;
  logic [NW-1:0]      n_r, iss_r;
  logic               p1_v_r, p2_v_r, p3_v_r;
  logic [KW-1:0]      p1_k_r, p2_k_r, p3_k_r, e_r;
  logic signed [63:0] prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [31:0] dot_r, s_r, d_r;
  logic               bump_r;
  logic               out_valid_r;
  out_item_t          out_r;

  // tables
  logic signed [31:0] vec_mem [MAX_REFLECTORS * WINDOW];
  logic signed [31:0] tau_mem [MAX_REFLECTORS];
  logic signed [31:0] h_q, tau_q;
  logic [AW-1:0]      vec_ra, vec_wa;
  logic               vec_we, tau_we;

  // column bookkeeping
  logic [CW-1:0] nr_c, n_c, last_c, r_c;
  logic          fill_c;
  logic [KW-1:0] rd_idx;
  logic signed [31:0] win_rd, mul_a, mul_b;
  logic signed [ACCW-1:0] acc_rnd;
  logic signed [31:0] acc_sat;
  logic          out_free, issuing;
  logic [31:0]   row_c;

  always_comb begin
    if (cfg.num_reflectors == 7'd0) nr_c = CW'(1);
    else if (32'(cfg.num_reflectors) > 32'(MAX_REFLECTORS)) nr_c = CW'(MAX_REFLECTORS);
    else nr_c = CW'(cfg.num_reflectors);
    if (cfg.reflector_len == 6'd0) n_c = CW'(1);
    else if (32'(cfg.reflector_len) > 32'(WINDOW)) n_c = CW'(WINDOW);
    else n_c = CW'(cfg.reflector_len);
    last_c = nr_c + n_c - CW'(2);
    fill_c = rows_seen_r < (n_c - CW'(1));
    r_c    = (rows_seen_r >= last_c) ? CW'(0) : last_c - rows_seen_r;
  end

  assign pop_ready = (state_r == S_IDLE);
  assign issuing   = iss_r < n_r;
  assign vec_ra    = AW'(32'(r_r) * WINDOW + 32'(iss_r));
  assign vec_wa    = AW'(32'(pop_cmd.ri) * WINDOW + 32'(pop_cmd.ei));
  assign vec_we    = pop_valid && pop_ready && pop_cmd.kind == CMD_VEC;
  assign tau_we    = pop_valid && pop_ready && pop_cmd.kind == CMD_TAU;

  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_wa] <= pop_cmd.val;
    h_q <= vec_mem[vec_ra];
  end

  always_ff @(posedge clk) begin
    if (tau_we) tau_mem[RIW'(pop_cmd.ri)] <= pop_cmd.val;
    tau_q <= tau_mem[r_r];
  end

  always_comb begin
    case (state_r)
      S_DOT:   rd_idx = p1_k_r;
      S_UPD:   rd_idx = p3_k_r;
      default: rd_idx = e_r;
    endcase
  end
  assign win_rd = win_r[rd_idx];

  always_comb begin
    case (state_r)
      S_DOT: begin
        mul_a = win_rd;
        mul_b = h_q;
      end
      S_TMUL: begin
        mul_a = dot_r;
        mul_b = tau_q;
      end
      default: begin
        mul_a = s_r;
        mul_b = h_q;
      end
    endcase
  end

  // exact sum rounded to nearest, then saturated
  always_comb begin
    acc_rnd = (acc_r + ACCW'(268435456)) >>> 29;
    if (acc_rnd > ACCW'(64'sd2147483647)) acc_sat = 32'h7fffffff;
    else if (acc_rnd < -ACCW'(64'sd2147483648)) acc_sat = 32'h80000000;
    else acc_sat = acc_rnd[31:0];
  end

  assign out_free = !out_valid_r || out_ready;
  assign row_c    = 32'(r_r) + 32'(n_r) - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_seen_r <= '0;
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      bump_r      <= 1'b0;
      for (int k = 0; k < WINDOW; k++) win_r[k] <= '0;
    end else begin
      // in S_EMIT the output register is reloaded below whenever it frees up
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop_valid && pop_cmd.kind == CMD_ROW) begin
            win_r[0] <= pop_cmd.val;
            n_r      <= NW'(n_c);
            r_r      <= RIW'(r_c);
            iss_r    <= '0;
            acc_r    <= '0;
            p1_v_r   <= 1'b0;
            p2_v_r   <= 1'b0;
            p3_v_r   <= 1'b0;
            if (fill_c) begin
              bump_r  <= 1'b1;
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_DOT;
            end
          end
        end
        S_SHIFT: begin
          for (int k = 1; k < WINDOW; k++) begin
            if (k < 32'(n_r)) win_r[k] <= win_r[k-1];
          end
          if (bump_r) rows_seen_r <= rows_seen_r + CW'(1);
          state_r <= S_IDLE;
        end
        S_DOT: begin
          p1_v_r <= issuing;
          p1_k_r <= KW'(iss_r);
          if (issuing) iss_r <= iss_r + NW'(1);
          if (p1_v_r) prod_r <= mul_a * mul_b;
          p2_v_r <= p1_v_r;
          if (p2_v_r) acc_r <= acc_r + ACCW'(prod_r);
          if (!issuing && !p1_v_r && !p2_v_r) state_r <= S_DOTR;
        end
        S_DOTR: begin
          dot_r   <= acc_sat;
          state_r <= S_TMUL;
        end
        S_TMUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_TRND;
        end
        S_TRND: begin
          s_r     <= round_sat64(prod_r);
          iss_r   <= '0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          p1_v_r <= issuing;
          p1_k_r <= KW'(iss_r);
          if (issuing) iss_r <= iss_r + NW'(1);
          if (p1_v_r) prod_r <= mul_a * mul_b;
          p2_v_r <= p1_v_r;
          p2_k_r <= p1_k_r;
          if (p2_v_r) d_r <= round_sat64(prod_r);
          p3_v_r <= p2_v_r;
          p3_k_r <= p2_k_r;
          if (p3_v_r) win_r[p3_k_r] <= sub_sat(win_rd, d_r);
          if (!issuing && !p1_v_r && !p2_v_r && !p3_v_r) begin
            e_r     <= KW'(n_r - NW'(1));
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.out_value   <= win_rd;
            if (r_r != '0) begin
              out_r.out_row     <= row_c[6:0];
              out_r.column_done <= 1'b0;
              bump_r            <= 1'b1;
              state_r           <= S_SHIFT;
            end else begin
              out_r.out_row     <= 7'(e_r);
              out_r.column_done <= (e_r == '0);
              if (e_r == '0) begin
                rows_seen_r <= '0;
                state_r     <= S_IDLE;
              end else begin
                e_r <= e_r - KW'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/householder_sliding_window_apply_core.sv =====
// householder_sliding_window_apply_core: APB registers, front, queue and back.
// Depends on hswa_pkg, hswa_front, hswa_fifo, hswa_back.
// One shared multiplier walks the window twice per reflector row; output stalls
// hold the back. The queue stores each accepted command for the back.
// Reset (rst_n low, synchronous) sets num_reflectors to 1 and reflector_len to 32
// and clears window, row count, queue and out valid.
module householder_sliding_window_apply_core #(
  parameter int WINDOW         = 32,
  parameter int MAX_REFLECTORS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hswa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hswa_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hswa_pkg::*;

  localparam logic REG_NUM_REFL = 1'b0;
  localparam logic REG_REFL_LEN = 1'b1;

  cfg_t cfg_r;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  // config port: zero wait states, register index is the word address
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_reflectors <= 7'd1;
      cfg_r.reflector_len  <= 6'd32;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NUM_REFL: cfg_r.num_reflectors <= pwdata[6:0];
        REG_REFL_LEN: cfg_r.reflector_len  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_REFL: prdata = 32'(cfg_r.num_reflectors);
      REG_REFL_LEN: prdata = 32'(cfg_r.reflector_len);
      default:      prdata = '0;
    endcase
  end

  // front: classify and drop no-op transactions
  hswa_front #(.WINDOW(WINDOW), .MAX_REFLECTORS(MAX_REFLECTORS)) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short queue so the front keeps taking loads while the back computes
  hswa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: tables, window, shared multiplier, output register
  hswa_back #(.WINDOW(WINDOW), .MAX_REFLECTORS(MAX_REFLECTORS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/hswa_checker.sv =====
// hswa_checker: port-level assertions for the top level, bound in below.
// Depends on hswa_pkg and householder_sliding_window_apply_core.
module hswa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input hswa_pkg::out_item_t out_data
);
  import hswa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_done_row0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.column_done |-> out_data.out_row == 7'd0)
    else $error("column end not on row 0");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind householder_sliding_window_apply_core hswa_checker u_hswa_checker (.*);

// ===== verif/hswa_checker.sv =====
`timescale 1ns / 1ps
// hswa_scoreboard: watches the input, result and register ports of the block,
// predicts every result and compares it field by field. Depends on hswa_pkg.
module hswa_scoreboard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hswa_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hswa_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen,
  output int                  columns_seen,
  output int                  rows_seen_total
);
  import hswa_pkg::*;

  localparam int WIN  = 32;
  localparam int NREF = 64;

  logic signed [31:0] win_q [WIN];
  logic signed [31:0] vec_tab [NREF*WIN];
  logic signed [31:0] tau_tab [NREF];
  int unsigned        row_cnt;
  logic [6:0]         num_refl_reg;
  logic [5:0]         refl_len_reg;
  out_item_t          expected_q [$];

  function automatic logic signed [31:0] round_q29(input logic signed [71:0] x);
    logic signed [71:0] t;
    t = (x + 72'sd268435456) >>> 29;
    if (t > 72'sd2147483647) return 32'sh7fffffff;
    if (t < -72'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] mul_q29(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [71:0] pa, pb;
    pa = a;
    pb = b;
    return round_q29(pa * pb);
  endfunction

  task automatic push_result(input int row, input logic signed [31:0] v, input bit done);
    out_item_t e;
    e.out_row     = row[6:0];
    e.out_value   = v;
    e.column_done = done;
    expected_q.push_back(e);
  endtask

  // One column row through the window: fill, or apply a reflector and emit.
  task automatic apply_row(input logic signed [31:0] val);
    int unsigned nr, n, last, r;
    logic signed [71:0] acc, pa, pb, diff;
    logic signed [31:0] dot, s, h, d;
    nr = (num_refl_reg < 1) ? 1 : ((num_refl_reg > NREF) ? NREF : num_refl_reg);
    n  = (refl_len_reg < 1) ? 1 : ((refl_len_reg > WIN) ? WIN : refl_len_reg);
    last = nr + n - 2;
    win_q[0] = val;
    if (row_cnt < n - 1) begin
      for (int k = n - 1; k >= 1; k--) win_q[k] = win_q[k-1];
      row_cnt++;
      return;
    end
    r = (row_cnt >= last) ? 0 : last - row_cnt;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      pa = win_q[k];
      pb = vec_tab[r*WIN + k];
      acc += pa * pb;
    end
    dot = round_q29(acc);
    s = mul_q29(dot, tau_tab[r]);
    for (int k = 0; k < n; k++) begin
      h = vec_tab[r*WIN + k];
      d = mul_q29(s, h);
      pa = win_q[k];
      pb = d;
      diff = pa - pb;
      if (diff > 72'sd2147483647) win_q[k] = 32'sh7fffffff;
      else if (diff < -72'sd2147483648) win_q[k] = 32'sh80000000;
      else win_q[k] = diff[31:0];
    end
    if (r == 0) begin
      for (int k = n; k >= 1; k--) push_result(k - 1, win_q[k-1], k == 1);
      row_cnt = 0;
      return;
    end
    push_result(r + n - 1, win_q[n-1], 1'b0);
    for (int k = n - 1; k >= 1; k--) win_q[k] = win_q[k-1];
    row_cnt++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int k = 0; k < WIN; k++) win_q[k] = '0;
      row_cnt = 0;
      num_refl_reg = 7'd1;
      refl_len_reg = 6'd32;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
      columns_seen = 0;
      rows_seen_total = 0;
    end else begin
      // result side first: expectations pushed this edge belong to later results
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: row %0d value %0d",
                 out_data.out_row, out_data.out_value);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.out_row !== e.out_row) begin
            $error("out_row: expected %0d actual %0d", e.out_row, out_data.out_row);
            fail_count++;
          end
          if (out_data.out_value !== e.out_value) begin
            $error("out_value: expected %0d actual %0d", e.out_value, out_data.out_value);
            fail_count++;
          end
          if (out_data.column_done !== e.column_done) begin
            $error("column_done: expected %0d actual %0d",
                   e.column_done, out_data.column_done);
            fail_count++;
          end
          if (e.column_done) columns_seen++;
        end
      end
      // register read-back
      if (psel && penable && !pwrite && pready) begin
        if (paddr == ADDR_NUM_REFL && prdata !== {25'd0, num_refl_reg}) begin
          $error("prdata: expected %0d actual %0d", num_refl_reg, prdata);
          fail_count++;
        end
        if (paddr == ADDR_REFL_LEN && prdata !== {26'd0, refl_len_reg}) begin
          $error("prdata: expected %0d actual %0d", refl_len_reg, prdata);
          fail_count++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_NUM_REFL) num_refl_reg = pwdata[6:0];
        else if (paddr == ADDR_REFL_LEN) refl_len_reg = pwdata[5:0];
      end
      if (in_valid && in_ready) begin
        case (in_data.op)
          OP_VEC: vec_tab[in_data.reflector_index*WIN + in_data.element_index] =
                    in_data.data_value;
          OP_TAU: tau_tab[in_data.reflector_index] = in_data.data_value;
          OP_ROW: begin
            rows_seen_total++;
            apply_row(in_data.data_value);
          end
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/householder_sliding_window_apply_core_tb.sv =====
`timescale 1ns / 1ps
// householder_sliding_window_apply_core_tb: stimulus, handshake pacing and
// verdict. Depends on hswa_pkg, hswa_scoreboard and the block's RTL.
module householder_sliding_window_apply_core_tb;
  import hswa_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;          // unused op, block drops it
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 300;             // outlasts a column-ending row without output stalls
  localparam int NUM_PHASES = 8;
  localparam int ROWS_PER_PHASE = 40;
  localparam int NUM_LOADED_REFL = 5;            // reflectors 0..4 are loaded
  localparam int SHORT_LEN = 8;                  // elements loaded for reflectors 1..4

  logic       clk;
  logic       rst_n;
  logic       in_valid, in_ready;
  in_item_t   in_data;
  logic       out_valid, out_ready;
  out_item_t  out_data;
  logic       psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  int  fail_count, pending, results_seen, columns_seen, rows_total;
  int  cycles;
  bit  calm;        // no idling on either side while set
  bit  hold_req;    // asks the receiver for one long hold-off

  // per-phase register values; includes zero and an out-of-range (clamped) length.
  // Only reflector 0 runs with lengths above SHORT_LEN, and no count exceeds
  // NUM_LOADED_REFL, so every row reads loaded table entries.
  logic [6:0] phase_nr [NUM_PHASES] = '{7'd1, 7'd1, 7'd0, 7'd3, 7'd1, 7'd5, 7'd2, 7'd4};
  logic [5:0] phase_n  [NUM_PHASES] = '{6'd32, 6'd1, 6'd0, 6'd8, 6'd63, 6'd4, 6'd8, 6'd2};

  householder_sliding_window_apply_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hswa_scoreboard u_scoreboard (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
    .fail_count, .pending, .results_seen, .columns_seen,
    .rows_seen_total(rows_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    bit held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (700) @(posedge clk);
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // Q2.29 data: mostly within +-1.0, some extremes, some raw 32-bit patterns.
  function automatic logic signed [31:0] rand_q29();
    int unsigned m;
    m = $urandom_range(99);
    if (m < 8) begin
      case ($urandom_range(3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh00000000;
        default: return 32'shffffffff;
      endcase
    end
    if (m < 22) return $urandom;
    return $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  // in_valid is left high so back-to-back items need no second assignment.
  task automatic send(input logic [1:0] op, input logic [5:0] ri, input logic [4:0] ei,
                      input logic signed [31:0] v);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, reflector_index: ri, element_index: ei, data_value: v};
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // read-back; the scoreboard compares prdata at the access edge
  task automatic reg_read(input logic [2:0] addr);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  // Idle point: all results back, then room for a fill row still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    calm = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry that a later row can read.
    for (int r = 0; r < NUM_LOADED_REFL; r++) begin
      for (int e = 0; e < ((r == 0) ? 32 : SHORT_LEN); e++)
        send(OP_VEC, r[5:0], e[4:0], rand_q29());
      send(OP_TAU, r[5:0], 5'd0, rand_q29());
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      // writes between phases may land mid-column: the row count is kept
      reg_write(ADDR_NUM_REFL, {25'd0, phase_nr[ph]});
      reg_write(ADDR_REFL_LEN, {26'd0, phase_n[ph]});
      reg_read(ADDR_NUM_REFL);
      reg_read(ADDR_REFL_LEN);
      calm = (ph == 2);
      if (ph == 6) hold_req = 1;

      if (ph == 1) begin
        // Directed, single-row columns: the dropped op, saturating tables
        // and extreme row values.
        send(OP_NOP, 6'h3f, 5'h1f, 32'shffffffff);
        send(OP_NOP, 6'h00, 5'h00, 32'sh0);
        send(OP_ROW, 6'd0, 5'd0, 32'sh7fffffff);
        send(OP_ROW, 6'd0, 5'd0, 32'sh80000000);
        send(OP_VEC, 6'd0, 5'd0, 32'sh80000000);
        send(OP_TAU, 6'd0, 5'd0, 32'sh7fffffff);
        send(OP_ROW, 6'd0, 5'd0, 32'sh7fffffff);
        send(OP_ROW, 6'd0, 5'd0, 32'sh80000000);
        send(OP_ROW, 6'd0, 5'd0, 32'sh00000000);
        send(OP_ROW, 6'd0, 5'd0, 32'shffffffff);
        send(OP_VEC, 6'd0, 5'd0, 32'sh20000000);
        send(OP_TAU, 6'd0, 5'd0, 32'sh20000000);
        send(OP_ROW, 6'd0, 5'd0, 32'sh20000000);
      end

      // Mostly column rows; loads in between must not disturb the column.
      for (int i = 0; i < ROWS_PER_PHASE; i++) begin
        case ($urandom_range(19))
          0: send(OP_NOP, 6'($urandom), 5'($urandom), 32'($urandom));
          1: send(OP_VEC, 6'($urandom), 5'($urandom), rand_q29());
          2: send(OP_TAU, 6'($urandom), 5'($urandom), rand_q29());
          default: ;
        endcase
        send(OP_ROW, 6'($urandom), 5'($urandom), rand_q29());
      end
    end

    settle();
    if (pending != 0) $error("results still expected after drain: %0d", pending);

    $display("covered %0d column rows, %0d results checked, %0d column flushes",
             rows_total, results_seen, columns_seen);
    $display("across %0d register settings incl. clamped values and a long output stall",
             NUM_PHASES);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
